// ----- rtl/wmrbp_pkg.sv -----
package wmrbp_pkg;

  // largest number of payload bytes one frame may hold
  localparam int unsigned PAYLOAD_MAX = 128;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_C   = 8'h43;
  localparam logic [7:0] CH_UC_E   = 8'h45;
  localparam logic [7:0] CH_UC_M   = 8'h4D;
  localparam logic [7:0] CH_UC_Q   = 8'h51;
  localparam logic [7:0] CH_UC_R   = 8'h52;
  localparam logic [7:0] CH_UC_S   = 8'h53;
  localparam logic [7:0] CH_UC_T   = 8'h54;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_M   = 8'h6D;
  localparam logic [7:0] CH_LC_O   = 8'h6F;
  localparam logic [7:0] CH_LC_P   = 8'h70;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_S   = 8'h73;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [1:0] LINK_EV_NONE = 2'd0;
  localparam logic [1:0] LINK_EV_DOWN = 2'd1;
  localparam logic [1:0] LINK_EV_UP   = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_ack;
  } in_item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    logic       frame_done;
    logic [7:0] frame_length;
    logic       frame_overflow;
    logic [1:0] link_event;
    logic       link_up;
    logic       time_sync_lost;
  } result_t;

  function automatic logic any3(input logic [7:0] c, input logic [7:0] a,
                                input logic [7:0] b, input logic [7:0] d);
    return (c == a) || (c == b) || (c == d);
  endfunction

endpackage

// ----- rtl/wifi_module_reply_byte_parser_core.sv -----
// channel | direction | ports
// --------+-----------+------------------------------------------------
// in      | input     | in_valid, in_stall, in_rx_byte, in_frame_ack
// out     | output    | out_valid, out_stall, out_payload_* .. out_time_sync_lost
//
// one item per cycle sustained while out_stall is low; an item is held first in
// the input register and then in the result register before its result shows.
// the parser state advances as an item moves from the input register to the
// result register. rst_n is synchronous and clears the parse state and the
// valid flags. out_stall holds the result register and, once the input
// register is also full, raises in_stall in the same cycle.
module wifi_module_reply_byte_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_ack,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_byte,
  output logic [6:0] out_payload_index,
  output logic       out_frame_done,
  output logic [7:0] out_frame_length,
  output logic       out_frame_overflow,
  output logic [1:0] out_link_event,
  output logic       out_link_up,
  output logic       out_time_sync_lost
);

  logic                in_valid_r;
  wmrbp_pkg::in_item_t in_item_r;
  logic                out_valid_r;
  wmrbp_pkg::result_t  res_r;
  wmrbp_pkg::result_t  res;
  logic                advance;

  // item moves on when the result register is empty or being taken
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  wmrbp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r.rx_byte   <= in_rx_byte;
      in_item_r.frame_ack <= in_frame_ack;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_valid  = res_r.payload_valid;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_payload_index  = res_r.payload_index;
  assign out_frame_done     = res_r.frame_done;
  assign out_frame_length   = res_r.frame_length;
  assign out_frame_overflow = res_r.frame_overflow;
  assign out_link_event     = res_r.link_event;
  assign out_link_up        = res_r.link_up;
  assign out_time_sync_lost = res_r.time_sync_lost;

endmodule

// ----- rtl/wmrbp_parser.sv -----
module wmrbp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  wmrbp_pkg::in_item_t item,
  output wmrbp_pkg::result_t  res
);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_HDR1     = 4'd1,
    ST_HDR2     = 4'd2,
    ST_HDR3     = 4'd3,
    ST_HDR4     = 4'd4,
    ST_HDR5     = 4'd5,
    ST_HDR6     = 4'd6,
    ST_HDR7     = 4'd7,
    ST_HDR8     = 4'd8,
    ST_PAYLOAD  = 4'd9,
    ST_DROP     = 4'd11,
    ST_TE_T     = 4'd12,
    ST_TE_E     = 4'd13,
    ST_TE_COLON = 4'd14,
    ST_TE_DIGIT = 4'd15
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] count_r, count_nxt;
  logic       pending_r, pending_nxt;
  logic       link_r, link_nxt;

  logic [7:0] c;
  logic [7:0] count_inc;
  logic       clr;

  assign c         = item.rx_byte;
  assign count_inc = count_r + 8'd1;

  always_comb begin
    state_nxt   = ST_IDLE;
    clr         = 1'b1;
    pending_nxt = pending_r & ~item.frame_ack;
    link_nxt    = link_r;
    count_nxt   = count_r;
    res         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (wmrbp_pkg::any3(c, wmrbp_pkg::CH_LC_P, wmrbp_pkg::CH_UC_E, wmrbp_pkg::CH_UC_T)) begin
          state_nxt = ST_HDR1;
          clr       = 1'b0;
        end
      end
      ST_HDR1: begin
        // this position waits out mismatches instead of restarting
        state_nxt = ST_HDR1;
        if (wmrbp_pkg::any3(c, wmrbp_pkg::CH_LC_A, wmrbp_pkg::CH_UC_R, wmrbp_pkg::CH_UC_C)) begin
          state_nxt = ST_HDR2;
          clr       = 1'b0;
        end
      end
      ST_HDR2: begin
        if (wmrbp_pkg::any3(c, wmrbp_pkg::CH_LC_R, wmrbp_pkg::CH_UC_R, wmrbp_pkg::CH_UC_M)) begin
          state_nxt = ST_HDR3;
          clr       = 1'b0;
        end
      end
      ST_HDR3: begin
        if (wmrbp_pkg::any3(c, wmrbp_pkg::CH_LC_A, wmrbp_pkg::CH_LC_O, wmrbp_pkg::CH_UC_Q)) begin
          state_nxt = ST_HDR4;
          clr       = 1'b0;
        end
      end
      ST_HDR4: begin
        if (wmrbp_pkg::any3(c, wmrbp_pkg::CH_LC_M, wmrbp_pkg::CH_UC_R, wmrbp_pkg::CH_UC_T)) begin
          state_nxt = ST_HDR5;
          clr       = 1'b0;
        end
      end
      ST_HDR5: begin
        if (wmrbp_pkg::any3(c, wmrbp_pkg::CH_LC_S, wmrbp_pkg::CH_COLON, wmrbp_pkg::CH_UC_T)) begin
          state_nxt = ST_HDR6;
          clr       = 1'b0;
        end
      end
      ST_HDR6: begin
        if (wmrbp_pkg::any3(c, wmrbp_pkg::CH_DQUOTE, wmrbp_pkg::CH_2, wmrbp_pkg::CH_UC_S)) begin
          state_nxt = ST_HDR7;
          clr       = 1'b0;
        end
      end
      ST_HDR7: begin
        if (wmrbp_pkg::any3(c, wmrbp_pkg::CH_COLON, wmrbp_pkg::CH_0, wmrbp_pkg::CH_UC_T)) begin
          state_nxt = ST_HDR8;
          clr       = 1'b0;
        end
      end
      ST_HDR8: begin
        clr = 1'b0;
        if (c == wmrbp_pkg::CH_LBRACE) begin
          state_nxt = ST_PAYLOAD;
        end else if (c == wmrbp_pkg::CH_8) begin
          state_nxt = ST_DROP;
        end else if (c == wmrbp_pkg::CH_UC_A) begin
          state_nxt = ST_TE_T;
        end else begin
          clr = 1'b1;
        end
      end
      ST_PAYLOAD: begin
        if (pending_nxt) begin
          // consumer has not taken the previous frame: drop this one
          pending_nxt = 1'b0;
        end else if (count_r >= 8'(wmrbp_pkg::PAYLOAD_MAX)) begin
          res.frame_overflow = 1'b1;
        end else begin
          res.payload_valid = 1'b1;
          res.payload_byte  = c;
          res.payload_index = count_r[6:0];
          count_nxt         = count_inc;
          if (c == wmrbp_pkg::CH_RBRACE || c == wmrbp_pkg::CH_LF) begin
            pending_nxt      = 1'b1;
            res.frame_done   = 1'b1;
            res.frame_length = count_inc;
          end else begin
            state_nxt = ST_PAYLOAD;
            clr       = 1'b0;
          end
        end
      end
      ST_DROP: begin
        link_nxt           = 1'b0;
        res.time_sync_lost = 1'b1;
      end
      ST_TE_T: begin
        if (c == wmrbp_pkg::CH_UC_T) begin
          state_nxt = ST_TE_E;
          clr       = 1'b0;
        end
      end
      ST_TE_E: begin
        if (c == wmrbp_pkg::CH_UC_E) begin
          state_nxt = ST_TE_COLON;
          clr       = 1'b0;
        end
      end
      ST_TE_COLON: begin
        if (c == wmrbp_pkg::CH_COLON) begin
          state_nxt = ST_TE_DIGIT;
          clr       = 1'b0;
        end
      end
      ST_TE_DIGIT: begin
        if (c == wmrbp_pkg::CH_0) begin
          link_nxt           = 1'b0;
          res.time_sync_lost = 1'b1;
        end else if (c == wmrbp_pkg::CH_1) begin
          link_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (clr) begin
      count_nxt = '0;
    end

    if (link_r && !link_nxt) begin
      res.link_event = wmrbp_pkg::LINK_EV_DOWN;
    end else if (!link_r && link_nxt) begin
      res.link_event = wmrbp_pkg::LINK_EV_UP;
    end else begin
      res.link_event = wmrbp_pkg::LINK_EV_NONE;
    end
    res.link_up = link_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      pending_r <= 1'b0;
      link_r    <= 1'b0;
    end else if (step_en) begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      pending_r <= pending_nxt;
      link_r    <= link_nxt;
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

  // parser states of the reply matcher
  localparam logic [3:0] ST_START     = 4'd0;
  localparam logic [3:0] ST_HDR1      = 4'd1;
  localparam logic [3:0] ST_HDR7      = 4'd7;
  localparam logic [3:0] ST_HDR8      = 4'd8;
  localparam logic [3:0] ST_PAYLOAD   = 4'd9;
  localparam logic [3:0] ST_LINK_DROP = 4'd11;
  localparam logic [3:0] ST_GOT_A     = 4'd12;
  localparam logic [3:0] ST_GOT_T     = 4'd13;
  localparam logic [3:0] ST_GOT_E     = 4'd14;
  localparam logic [3:0] ST_GOT_COLON = 4'd15;

  localparam int RANDOM_ITEMS = 1950;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_frame_ack = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_payload_valid;
  logic [7:0] out_payload_byte;
  logic [6:0] out_payload_index;
  logic       out_frame_done;
  logic [7:0] out_frame_length;
  logic       out_frame_overflow;
  logic [1:0] out_link_event;
  logic       out_link_up;
  logic       out_time_sync_lost;

  // mirror of the parser state
  logic [3:0] parse_state = ST_START;
  logic [7:0] payload_count = 8'd0;
  logic       frame_pending = 1'b0;
  logic       link_flag = 1'b0;

  wmrbp_pkg::result_t expected_replies[$];
  int      n_errors = 0;
  int      items_sent = 0;
  int      burst_left = 0;
  int      stall_timer = 0;
  int      stall_mode = 0;

  always #4 clk = ~clk;

  wifi_module_reply_byte_parser_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .in_frame_ack      (in_frame_ack),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_valid (out_payload_valid),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_done    (out_frame_done),
    .out_frame_length  (out_frame_length),
    .out_frame_overflow(out_frame_overflow),
    .out_link_event    (out_link_event),
    .out_link_up       (out_link_up),
    .out_time_sync_lost(out_time_sync_lost)
  );

  // one of the three accepted characters at each header position
  function automatic logic [7:0] header_char(input logic [3:0] pos, input int alt);
    logic [23:0] opts;
    case (pos)
      4'd0:    opts = {wmrbp_pkg::CH_UC_T, wmrbp_pkg::CH_UC_E, wmrbp_pkg::CH_LC_P};
      4'd1:    opts = {wmrbp_pkg::CH_UC_C, wmrbp_pkg::CH_UC_R, wmrbp_pkg::CH_LC_A};
      4'd2:    opts = {wmrbp_pkg::CH_UC_M, wmrbp_pkg::CH_UC_R, wmrbp_pkg::CH_LC_R};
      4'd3:    opts = {wmrbp_pkg::CH_UC_Q, wmrbp_pkg::CH_LC_O, wmrbp_pkg::CH_LC_A};
      4'd4:    opts = {wmrbp_pkg::CH_UC_T, wmrbp_pkg::CH_UC_R, wmrbp_pkg::CH_LC_M};
      4'd5:    opts = {wmrbp_pkg::CH_UC_T, wmrbp_pkg::CH_COLON, wmrbp_pkg::CH_LC_S};
      4'd6:    opts = {wmrbp_pkg::CH_UC_S, wmrbp_pkg::CH_2, wmrbp_pkg::CH_DQUOTE};
      default: opts = {wmrbp_pkg::CH_UC_T, wmrbp_pkg::CH_0, wmrbp_pkg::CH_COLON};
    endcase
    return opts[8*alt +: 8];
  endfunction

  function automatic wmrbp_pkg::result_t predict_reply(input logic [7:0] c, input logic ack);
    wmrbp_pkg::result_t r;
    logic       old_link;
    logic [3:0] nxt;
    logic       clr;
    r = '0;
    old_link = link_flag;
    nxt = ST_START;
    clr = 1'b1;
    if (ack) frame_pending = 1'b0;
    if (parse_state <= ST_HDR7) begin
      if (c == header_char(parse_state, 0) || c == header_char(parse_state, 1) ||
          c == header_char(parse_state, 2)) begin
        nxt = parse_state + 4'd1;
        clr = 1'b0;
      end else if (parse_state == ST_HDR1) begin
        nxt = ST_HDR1;
      end
    end else begin
      case (parse_state)
        ST_HDR8: begin
          clr = 1'b0;
          if (c == wmrbp_pkg::CH_LBRACE) nxt = ST_PAYLOAD;
          else if (c == wmrbp_pkg::CH_8) nxt = ST_LINK_DROP;
          else if (c == wmrbp_pkg::CH_UC_A) nxt = ST_GOT_A;
          else clr = 1'b1;
        end
        ST_PAYLOAD: begin
          if (frame_pending) begin
            frame_pending = 1'b0;
          end else if (payload_count >= wmrbp_pkg::PAYLOAD_MAX) begin
            r.frame_overflow = 1'b1;
          end else begin
            r.payload_valid = 1'b1;
            r.payload_byte = c;
            r.payload_index = payload_count[6:0];
            payload_count = payload_count + 8'd1;
            if (c == wmrbp_pkg::CH_RBRACE || c == wmrbp_pkg::CH_LF) begin
              frame_pending = 1'b1;
              r.frame_done = 1'b1;
              r.frame_length = payload_count;
            end else begin
              nxt = ST_PAYLOAD;
              clr = 1'b0;
            end
          end
        end
        ST_LINK_DROP: begin
          link_flag = 1'b0;
          r.time_sync_lost = 1'b1;
        end
        ST_GOT_A: if (c == wmrbp_pkg::CH_UC_T) begin
          nxt = ST_GOT_T;
          clr = 1'b0;
        end
        ST_GOT_T: if (c == wmrbp_pkg::CH_UC_E) begin
          nxt = ST_GOT_E;
          clr = 1'b0;
        end
        ST_GOT_E: if (c == wmrbp_pkg::CH_COLON) begin
          nxt = ST_GOT_COLON;
          clr = 1'b0;
        end
        ST_GOT_COLON: begin
          if (c == wmrbp_pkg::CH_0) begin
            link_flag = 1'b0;
            r.time_sync_lost = 1'b1;
          end else if (c == wmrbp_pkg::CH_1) begin
            link_flag = 1'b1;
          end
        end
        default: ;
      endcase
    end
    parse_state = nxt;
    if (clr) payload_count = 8'd0;
    if (old_link && !link_flag) r.link_event = wmrbp_pkg::LINK_EV_DOWN;
    else if (!old_link && link_flag) r.link_event = wmrbp_pkg::LINK_EV_UP;
    else r.link_event = wmrbp_pkg::LINK_EV_NONE;
    r.link_up = link_flag;
    return r;
  endfunction

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_ack();
    return ($urandom_range(0, 5) == 0);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic ack);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_frame_ack <= ack;
    do @(posedge clk); while (in_stall);
    expected_replies.push_back(predict_reply(b, ack));
    items_sent++;
  endtask

  // header with optional mismatches held in state one and an optional break
  task automatic send_header(input int hold_bytes, input bit allow_break, output bit reached);
    int         fixed_alt;
    int         break_at;
    int         alt;
    logic [7:0] b;
    fixed_alt = $urandom_range(0, 3);
    break_at = allow_break ? $urandom_range(0, 7) : 8;
    reached = 1'b1;
    for (int pos = 0; pos < 8 && reached; pos++) begin
      if (pos == break_at) begin
        send_item(random_byte(), rand_ack());
        reached = 1'b0;
      end else begin
        if (pos == 1) begin
          repeat (hold_bytes) begin
            do b = random_byte();
            while (b == wmrbp_pkg::CH_LC_A || b == wmrbp_pkg::CH_UC_R ||
                   b == wmrbp_pkg::CH_UC_C);
            send_item(b, rand_ack());
          end
        end
        alt = (fixed_alt == 3) ? $urandom_range(0, 2) : fixed_alt;
        send_item(header_char(4'(pos), alt), rand_ack());
      end
    end
  endtask

  task automatic test_idle_extremes();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_short_frame();
    bit ok;
    send_header(1, 1'b0, ok);
    send_item(wmrbp_pkg::CH_LBRACE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(wmrbp_pkg::CH_RBRACE, 1'b0);
  endtask

  task automatic test_link_report();
    bit ok;
    send_header(0, 1'b0, ok);
    send_item(wmrbp_pkg::CH_UC_A, 1'b1);
    send_item(wmrbp_pkg::CH_UC_T, 1'b0);
    send_item(wmrbp_pkg::CH_UC_E, 1'b0);
    send_item(wmrbp_pkg::CH_COLON, 1'b0);
    send_item(wmrbp_pkg::CH_1, 1'b0);
  endtask

  task automatic test_random_traffic(input int n);
    int         stop_at;
    int         kind;
    int         len;
    int         break_at;
    bit         ok;
    bit         long_frame;
    logic [7:0] b;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(1, 4)) send_item(random_byte(), rand_ack());
      end else begin
        send_header(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0, kind < 20, ok);
        if (ok) begin
          if (kind < 60) begin
            // long frames can reach the full buffer and the overflow abort
            long_frame = ($urandom_range(0, 24) == 0);
            len = long_frame ? $urandom_range(120, 135) : $urandom_range(0, 12);
            send_item(wmrbp_pkg::CH_LBRACE, long_frame ? 1'b1 : rand_ack());
            repeat (len) begin
              do b = random_byte();
              while (b == wmrbp_pkg::CH_RBRACE || b == wmrbp_pkg::CH_LF);
              send_item(b, rand_ack());
            end
            if ($urandom_range(0, 7) != 0)
              send_item($urandom_range(0, 1) ? wmrbp_pkg::CH_RBRACE : wmrbp_pkg::CH_LF,
                        rand_ack());
          end else if (kind < 70) begin
            send_item(wmrbp_pkg::CH_8, rand_ack());
            send_item(random_byte(), rand_ack());
          end else if (kind < 92) begin
            break_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 3;
            send_item(wmrbp_pkg::CH_UC_A, rand_ack());
            send_item((break_at == 0) ? random_byte() : wmrbp_pkg::CH_UC_T, rand_ack());
            send_item((break_at == 1) ? random_byte() : wmrbp_pkg::CH_UC_E, rand_ack());
            send_item((break_at == 2) ? random_byte() : wmrbp_pkg::CH_COLON, rand_ack());
            case ($urandom_range(0, 3))
              0: b = wmrbp_pkg::CH_0;
              1: b = wmrbp_pkg::CH_1;
              2: b = 8'($urandom_range(wmrbp_pkg::CH_2, 8'h39));
              default: b = random_byte();
            endcase
            send_item(b, rand_ack());
          end else begin
            send_item(random_byte(), rand_ack());
          end
        end
      end
    end
  endtask

  // receiver stalls: none, light, heavy or periodic, switching now and then
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(20, 120);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_timer[2];
    endcase
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    wmrbp_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("result item with no item outstanding");
        n_errors++;
      end else begin
        want = expected_replies.pop_front();
        check_field("payload_valid", 8'(want.payload_valid), 8'(out_payload_valid));
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("payload_index", 8'(want.payload_index), 8'(out_payload_index));
        check_field("frame_done", 8'(want.frame_done), 8'(out_frame_done));
        check_field("frame_length", want.frame_length, out_frame_length);
        check_field("frame_overflow", 8'(want.frame_overflow), 8'(out_frame_overflow));
        check_field("link_event", 8'(want.link_event), 8'(out_link_event));
        check_field("link_up", 8'(want.link_up), 8'(out_link_up));
        check_field("time_sync_lost", 8'(want.time_sync_lost), 8'(out_time_sync_lost));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_extremes();
    test_short_frame();
    test_link_report();
    test_random_traffic(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wmrbp_pkg.sv
rtl/wmrbp_parser.sv
rtl/wifi_module_reply_byte_parser_core.sv
bench/tb.sv
